[sv/sfr_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the serial frame receiver.
package sfr_pkg;

  // Field widths.
  localparam int CmdW    = 2;
  localparam int ByteW   = 8;
  localparam int MsW     = 10;
  localparam int SecW    = 8;
  localparam int CrcW    = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 10;

  // Default frame buffer depth in bytes.
  localparam int FrameMaxDef = 53;

  // Input item commands.
  typedef enum logic [CmdW-1:0] {
    CMD_BYTE = 2'd0,
    CMD_MS   = 2'd1,
    CMD_SEC  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_GAP_LIMIT    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HOLD   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_HOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REPLY_DELAY  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FAULT_LIMIT  = 3'd4;

  // Register reset values.
  localparam logic [MsW-1:0]  GapLimitRst    = 10'd50;
  localparam logic [MsW-1:0]  FrameHoldRst   = 10'd50;
  localparam logic [MsW-1:0]  TimeoutHoldRst = 10'd10;
  localparam logic [MsW-1:0]  ReplyDelayRst  = 10'd10;
  localparam logic [SecW-1:0] FaultLimitRst  = 8'd30;

  // Receive hold is armed out of reset with a short delay.
  localparam logic [MsW-1:0]  RxHoldRst      = 10'd5;

  // Protocol byte values.
  localparam logic [ByteW-1:0] ADDR_TEST   = 8'h00;
  localparam logic [ByteW-1:0] ADDR_NORMAL = 8'h01;
  localparam logic [ByteW-1:0] FUNC_READ   = 8'h03;
  localparam logic [ByteW-1:0] FUNC_TEST   = 8'hAA;

  // CRC-16 (reflected polynomial) constants.
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

  // Countdown control bundle from the frame logic to a timer.
  typedef struct packed {
    logic           tick;
    logic           load;
    logic           clear;
    logic [MsW-1:0] load_val;
  } cd_ctrl_t;

  // One byte of the Modbus CRC-16, bit by bit.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/sfr_countdown.sv]
// Millisecond countdown that pulses once when it runs out.
module sfr_countdown #(
  parameter logic                  ARM_RST   = 1'b0,
  parameter logic [sfr_pkg::MsW-1:0] TIMER_RST = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfr_pkg::cd_ctrl_t   ctrl,
  output logic                expire
);
  import sfr_pkg::*;

  logic           armed_r, armed_nxt;
  logic [MsW-1:0] timer_r, timer_nxt;

  // Expiry is judged on the state before this item.
  assign expire = ctrl.tick && armed_r && (timer_r <= MsW'(1));

  // Clear wins over a load, and a load wins over counting.
  always_comb begin
    armed_nxt = armed_r;
    timer_nxt = timer_r;
    if (ctrl.clear) begin
      armed_nxt = 1'b0;
      timer_nxt = '0;
    end else if (ctrl.load) begin
      armed_nxt = 1'b1;
      timer_nxt = ctrl.load_val;
    end else if (ctrl.tick && armed_r) begin
      if (timer_r <= MsW'(1)) begin
        armed_nxt = 1'b0;
        timer_nxt = '0;
      end else begin
        timer_nxt = timer_r - MsW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= ARM_RST;
      timer_r <= TIMER_RST;
    end else begin
      armed_r <= armed_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

[sv/serial_frame_receiver_crc_check.sv]
// Top level of the serial frame receiver with CRC-16 request check.
//
// Each input transaction carries a received byte, a millisecond or second
// tick, or nothing, and yields exactly one result transaction in the next
// cycle. The block takes one transaction per clock, updating frame state,
// CRC-16 and all timers together; the result is registered, so in_stall
// rises only while a result is held and out_stall is high. Configuration
// writes are always ready; the user must issue them only while the block
// is idle (not checked). FRAME_MAX sets the frame buffer depth in bytes.
module serial_frame_receiver_crc_check #(
  parameter int FRAME_MAX = sfr_pkg::FrameMaxDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfr_pkg::CmdW-1:0]      in_cmd,
  input  logic [sfr_pkg::ByteW-1:0]     in_rx_byte,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_done,
  output logic                          out_frame_timed_out,
  output logic                          out_request_ok,
  output logic                          out_rx_allowed,
  output logic                          out_tx_allowed,
  output logic                          out_link_fault,
  output logic                          out_in_test_mode,
  output logic                          out_rx_busy,
  output logic [sfr_pkg::ByteW-1:0]     out_function_code,
  // Configuration channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sfr_pkg::CfgDatW-1:0]   cfg_data
);
  import sfr_pkg::*;

  localparam int IdxW = $clog2(FRAME_MAX + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(FRAME_MAX);

  // Configuration registers.
  logic [MsW-1:0]  gap_limit_r, frame_hold_r, timeout_hold_r, reply_delay_r;
  logic [SecW-1:0] fault_limit_r;

  // Frame state.
  logic            busy_r, busy_nxt;
  logic            test_mode_r, test_mode_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [ByteW-1:0] func_r, func_nxt;
  logic [CrcW-1:0] crc_r, crc_nxt;
  logic [ByteW-1:0] crc_lo_r, crc_lo_nxt, crc_hi_r, crc_hi_nxt;
  logic [MsW-1:0]  gap_r, gap_nxt;
  logic            fault_r, fault_nxt;
  logic [SecW-1:0] fault_tmr_r, fault_tmr_nxt;

  // Result register.
  logic            out_valid_r;
  logic            done_r, tmo_r, req_ok_r, rx_pulse_r, tx_pulse_r;
  logic            fault_out_r, test_out_r, busy_out_r;
  logic [ByteW-1:0] func_out_r;

  logic            in_accept;
  logic            done, tmo, req_ok;
  logic            rx_pulse, tx_pulse;
  cmd_t            cmd;
  cd_ctrl_t        rx_ctrl, tx_ctrl;

  // Intermediate values of the byte path.
  logic [IdxW-1:0] idx_inc;
  logic [ByteW-1:0] func_b;
  logic [CrcW-1:0] crc_b;
  logic [ByteW-1:0] lo_b, hi_b;
  logic [MsW-1:0]  gap_inc;
  logic [SecW-1:0] ftmr_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cmd       = cmd_t'(in_cmd);

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r    <= GapLimitRst;
      frame_hold_r   <= FrameHoldRst;
      timeout_hold_r <= TimeoutHoldRst;
      reply_delay_r  <= ReplyDelayRst;
      fault_limit_r  <= FaultLimitRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAP_LIMIT:    gap_limit_r    <= cfg_data;
        REG_FRAME_HOLD:   frame_hold_r   <= cfg_data;
        REG_TIMEOUT_HOLD: timeout_hold_r <= cfg_data;
        REG_REPLY_DELAY:  reply_delay_r  <= cfg_data;
        REG_FAULT_LIMIT:  fault_limit_r  <= cfg_data[SecW-1:0];
        default: ;
      endcase
    end
  end

  // Byte path values, as if the byte lands in a busy frame.
  always_comb begin
    idx_inc = (idx_r < IdxMax) ? idx_r + IdxW'(1) : idx_r;
    func_b  = (idx_r == IdxW'(1)) ? in_rx_byte : func_r;
    crc_b   = (idx_r < IdxW'(6)) ? crc_byte(crc_r, in_rx_byte) : crc_r;
    lo_b    = (idx_r == IdxW'(6)) ? in_rx_byte : crc_lo_r;
    hi_b    = (idx_r == IdxW'(7)) ? in_rx_byte : crc_hi_r;
    gap_inc = (gap_r != '1) ? gap_r + MsW'(1) : gap_r;
    ftmr_inc = (fault_tmr_r != '1) ? fault_tmr_r + SecW'(1) : fault_tmr_r;
  end

  // Next state for one accepted transaction.
  always_comb begin
    busy_nxt      = busy_r;
    test_mode_nxt = test_mode_r;
    idx_nxt       = idx_r;
    func_nxt      = func_r;
    crc_nxt       = crc_r;
    crc_lo_nxt    = crc_lo_r;
    crc_hi_nxt    = crc_hi_r;
    gap_nxt       = gap_r;
    fault_nxt     = fault_r;
    fault_tmr_nxt = fault_tmr_r;
    done          = 1'b0;
    tmo           = 1'b0;
    req_ok        = 1'b0;
    rx_ctrl       = '{tick: 1'b0, load: 1'b0, clear: 1'b0, load_val: frame_hold_r};
    tx_ctrl       = '{tick: 1'b0, load: 1'b0, clear: 1'b0, load_val: reply_delay_r};

    if (in_accept) begin
      unique case (cmd)
        CMD_BYTE: begin
          gap_nxt = '0;
          if (!busy_r) begin
            // Frame start on an address byte.
            if (in_rx_byte == ADDR_TEST ||
                (in_rx_byte == ADDR_NORMAL && !test_mode_r)) begin
              if (in_rx_byte == ADDR_TEST) begin
                test_mode_nxt = 1'b1;
              end
              busy_nxt = 1'b1;
              idx_nxt  = IdxW'(1);
              crc_nxt  = crc_byte(CrcInit, in_rx_byte);
            end
          end else begin
            func_nxt   = func_b;
            crc_nxt    = crc_b;
            crc_lo_nxt = lo_b;
            crc_hi_nxt = hi_b;
            idx_nxt    = idx_inc;
            // Frame end by length.
            if (!test_mode_r) begin
              done = (func_b == FUNC_READ && idx_inc >= IdxW'(8)) || idx_inc >= IdxMax;
            end else begin
              done = (func_b == FUNC_TEST && idx_inc >= IdxW'(8));
            end
            if (done) begin
              busy_nxt     = 1'b0;
              idx_nxt      = '0;
              rx_ctrl.load = 1'b1;
              req_ok = (func_b == FUNC_TEST) && (crc_b[7:0] == lo_b) &&
                       (crc_b[15:8] == hi_b);
              if (req_ok) begin
                tx_ctrl.load  = 1'b1;
                rx_ctrl.clear = 1'b1;
                fault_nxt     = 1'b0;
                fault_tmr_nxt = '0;
              end
            end
          end
        end
        CMD_MS: begin
          rx_ctrl.tick = 1'b1;
          tx_ctrl.tick = 1'b1;
          if (busy_r) begin
            gap_nxt = gap_inc;
            // Gap timeout ends the frame and rearms the receive hold.
            if (gap_inc >= gap_limit_r) begin
              gap_nxt          = '0;
              busy_nxt         = 1'b0;
              idx_nxt          = '0;
              tmo              = 1'b1;
              rx_ctrl.load     = 1'b1;
              rx_ctrl.load_val = timeout_hold_r;
            end
          end
        end
        CMD_SEC: begin
          if (!fault_r) begin
            fault_tmr_nxt = ftmr_inc;
            if (ftmr_inc >= fault_limit_r) begin
              fault_tmr_nxt = '0;
              fault_nxt     = 1'b1;
            end
          end
        end
        CMD_NONE: ;
        default: ;
      endcase
    end
  end

  // Receive hold and reply delay timers.
  sfr_countdown #(
    .ARM_RST   (1'b1),
    .TIMER_RST (RxHoldRst)
  ) u_rx_hold (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (rx_ctrl),
    .expire (rx_pulse)
  );

  sfr_countdown #(
    .ARM_RST   (1'b0),
    .TIMER_RST ('0)
  ) u_tx_delay (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (tx_ctrl),
    .expire (tx_pulse)
  );

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      test_mode_r <= 1'b0;
      idx_r       <= '0;
      func_r      <= '0;
      crc_r       <= CrcInit;
      crc_lo_r    <= '0;
      crc_hi_r    <= '0;
      gap_r       <= '0;
      fault_r     <= 1'b0;
      fault_tmr_r <= '0;
    end else begin
      busy_r      <= busy_nxt;
      test_mode_r <= test_mode_nxt;
      idx_r       <= idx_nxt;
      func_r      <= func_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      crc_hi_r    <= crc_hi_nxt;
      gap_r       <= gap_nxt;
      fault_r     <= fault_nxt;
      fault_tmr_r <= fault_tmr_nxt;
    end
  end

  // Result register; it loads whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      done_r      <= done;
      tmo_r       <= tmo;
      req_ok_r    <= req_ok;
      rx_pulse_r  <= rx_pulse;
      tx_pulse_r  <= tx_pulse;
      fault_out_r <= fault_nxt;
      test_out_r  <= test_mode_nxt;
      busy_out_r  <= busy_nxt;
      func_out_r  <= func_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_done      = done_r;
  assign out_frame_timed_out = tmo_r;
  assign out_request_ok      = req_ok_r;
  assign out_rx_allowed      = rx_pulse_r;
  assign out_tx_allowed      = tx_pulse_r;
  assign out_link_fault      = fault_out_r;
  assign out_in_test_mode    = test_out_r;
  assign out_rx_busy         = busy_out_r;
  assign out_function_code   = func_out_r;

endmodule

[sv/sfr_checker.sv]
// Port-level checks for the serial frame receiver, bound to the top level.
module sfr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_frame_done,
  input logic                        out_frame_timed_out,
  input logic                        out_request_ok,
  input logic                        out_link_fault,
  input logic                        out_rx_busy,
  input logic [sfr_pkg::ByteW-1:0]   out_function_code
);
  import sfr_pkg::*;

  // The input side is never held off while no result is waiting.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  // Every accepted transaction shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // A frame cannot end by length and by timeout at once.
  a_one_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_done && out_frame_timed_out))
    else $error("frame ended by length and by timeout together");

  // A valid request ends its frame, clears the link fault and leaves rx_busy low.
  a_req_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_ok |-> out_frame_done && !out_link_fault && !out_rx_busy)
    else $error("request accepted without a completed frame");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_function_code))
    else $error("stalled result changed");

endmodule

bind serial_frame_receiver_crc_check sfr_checker u_sfr_checker (.*);
